// File: src/jsu_pkg.sv
package jsu_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QDEPTH_DEF      = 2;
    localparam int CMD_UNITS       = 3;
    localparam int CAP_WIDTH       = 16;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'd256;

    // characters the decoder looks at
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;

    localparam logic [15:0] HI_SUR_LO = 16'hD800;
    localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SUR_LO = 16'hDC00;
    localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
    localparam logic [20:0] CP_SUPP   = 21'h10000;
    localparam logic [20:0] CP_REPL   = 21'h0FFFD;
    localparam logic [20:0] CP_LIM1   = 21'h80;
    localparam logic [20:0] CP_LIM2   = 21'h800;
    localparam logic [7:0]  UTF_CONT  = 8'h80;
    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_LEAD4 = 8'hF0;

    typedef enum logic [2:0] {
        PH_WS, PH_STR, PH_ESC, PH_HEX, PH_HI_BS, PH_HI_U, PH_HI_HEX, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_NOSTR = 2'd0,
        ST_OK    = 2'd1,
        ST_OVF   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        U_NONE, U_CP, U_RAW, U_STAT
    } t_ukind;

    // one output unit: a code point to encode, a raw byte, or the status
    typedef struct packed {
        t_ukind      kind;
        logic [20:0] val;
    } t_unit;

    // all results of one input transfer
    typedef struct packed {
        t_unit [CMD_UNITS-1:0] u;
        logic [1:0]            n;
    } t_cmd;

    function automatic logic [2:0] cp_len(input logic [20:0] cp);
        if (cp < CP_LIM1)      return 3'd1;
        else if (cp < CP_LIM2) return 3'd2;
        else if (cp < CP_SUPP) return 3'd3;
        else                   return 3'd4;
    endfunction

endpackage

// File: src/jsu_in_if.sv
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       has_byte;
    logic       span_end;

    modport source(output valid, in_byte, has_byte, span_end, input ready);
    modport sink(input valid, in_byte, has_byte, span_end, output ready);
endinterface

// File: src/jsu_out_if.sv
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic [1:0] status;
    logic       run_last;

    modport source(output valid, out_byte, is_status, status, run_last, input ready);
    modport sink(input valid, out_byte, is_status, status, run_last, output ready);
endinterface

// File: src/jsu_front.sv
module jsu_front #(
    parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    jsu_in_if.sink                              i_in,
    input  logic [jsu_pkg::CAP_WIDTH-1:0]       i_cap,
    input  logic                                i_q_full,
    output logic                                o_push,
    output jsu_pkg::t_cmd                       o_cmd
);
    import jsu_pkg::*;

    localparam int SW = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 2;

    typedef struct packed {
        t_phase                 ph;
        logic [2:0]             hcnt;
        logic [15:0]            hacc;
        logic                   hbad;
        logic [9:0]             pend;
        logic [COUNT_WIDTH-1:0] bw;
    } t_fst;

    t_fst r_st, n_st;
    logic w_acc;

    function automatic void push_unit(input t_ukind k, input logic [20:0] v, inout t_cmd c);
        c.u[c.n] = '{kind: k, val: v};
        c.n      = c.n + 2'd1;
    endfunction

    function automatic void finish(input t_status st, inout t_fst s, inout t_cmd c);
        push_unit(U_STAT, {19'd0, st}, c);
        s.ph = PH_DONE;
    endfunction

    // room check against capacity minus terminator; overflow replaces the unit
    function automatic logic put(input logic raw, input logic [20:0] cp,
                                 input logic [CAP_WIDTH-1:0] cap,
                                 inout t_fst s, inout t_cmd c);
        logic [2:0]    len;
        logic [SW-1:0] need;
        len  = raw ? 3'd1 : cp_len(cp);
        need = SW'(s.bw) + SW'(len) + SW'(1);
        if (need > SW'(cap)) begin
            finish(ST_OVF, s, c);
            return 1'b0;
        end
        push_unit(raw ? U_RAW : U_CP, cp, c);
        s.bw = s.bw + COUNT_WIDTH'(len);
        return 1'b1;
    endfunction

    function automatic void hex_clear(inout t_fst s);
        s.hcnt = 3'd0;
        s.hacc = 16'd0;
        s.hbad = 1'b0;
    endfunction

    function automatic void hex_take(input logic [7:0] b, inout t_fst s);
        logic [3:0] d;
        d = 4'd0;
        if (b >= CH_DIG_0 && b <= CH_DIG_9) begin
            d = b[3:0];
        end else if ((b >= CH_LO_A && b <= CH_LO_F) || (b >= CH_UP_A && b <= CH_UP_F)) begin
            d = b[3:0] + 4'd9;
        end else begin
            s.hbad = 1'b1;
        end
        s.hacc = {s.hacc[11:0], d};
        s.hcnt = s.hcnt + 3'd1;
    endfunction

    function automatic void finish_u(input logic [15:0] v, input logic bad,
                                     input logic [CAP_WIDTH-1:0] cap,
                                     inout t_fst s, inout t_cmd c);
        s.ph = PH_STR;
        if (bad) begin
            void'(put(1'b0, {13'd0, CH_QMARK}, cap, s, c));
        end else if (v >= HI_SUR_LO && v <= HI_SUR_HI) begin
            s.pend = v[9:0];
            s.ph   = PH_HI_BS;
        end else if (v >= LO_SUR_LO && v <= LO_SUR_HI) begin
            void'(put(1'b0, CP_REPL, cap, s, c));
        end else begin
            void'(put(1'b0, {5'd0, v}, cap, s, c));
        end
    endfunction

    function automatic void do_esc(input logic [7:0] e, input logic [CAP_WIDTH-1:0] cap,
                                   inout t_fst s, inout t_cmd c);
        s.ph = PH_STR;
        if (e == CH_LO_N)      void'(put(1'b0, {13'd0, CH_LF}, cap, s, c));
        else if (e == CH_LO_R) void'(put(1'b0, {13'd0, CH_CR}, cap, s, c));
        else if (e == CH_LO_T) void'(put(1'b0, {13'd0, CH_TAB}, cap, s, c));
        else if (e == CH_LO_B) void'(put(1'b0, {13'd0, CH_BS}, cap, s, c));
        else if (e == CH_LO_F) void'(put(1'b0, {13'd0, CH_FF}, cap, s, c));
        else if (e == CH_LO_U) begin
            hex_clear(s);
            s.ph = PH_HEX;
        end else begin
            void'(put(1'b0, {13'd0, e}, cap, s, c));
        end
    endfunction

    function automatic void do_str(input logic [7:0] b, input logic [CAP_WIDTH-1:0] cap,
                                   inout t_fst s, inout t_cmd c);
        if (b == CH_QUOTE)       finish(ST_OK, s, c);
        else if (b == CH_BSLASH) s.ph = PH_ESC;
        else                     void'(put(1'b1, {13'd0, b}, cap, s, c));
    endfunction

    assign i_in.ready = !i_q_full;
    assign w_acc      = i_in.valid && i_in.ready;

    always_comb begin
        t_fst       s;
        t_cmd       c;
        logic [7:0] b;
        s = r_st;
        c = '0;
        b = i_in.in_byte;

        if (i_in.has_byte) begin
            unique case (s.ph)
                PH_WS: begin
                    if (i_cap == '0) begin
                        finish(ST_NOSTR, s, c);
                    end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
                        s.ph = PH_WS;
                    end else if (b == CH_QUOTE) begin
                        s.ph = PH_STR;
                        s.bw = '0;
                    end else begin
                        finish(ST_NOSTR, s, c);
                    end
                end
                PH_STR: do_str(b, i_cap, s, c);
                PH_ESC: do_esc(b, i_cap, s, c);
                PH_HEX: begin
                    hex_take(b, s);
                    if (s.hcnt >= 3'd4) finish_u(s.hacc, s.hbad, i_cap, s, c);
                end
                PH_HI_BS: begin
                    if (b == CH_BSLASH) begin
                        s.ph = PH_HI_U;
                    end else begin
                        s.ph = PH_STR;
                        if (put(1'b0, CP_REPL, i_cap, s, c)) do_str(b, i_cap, s, c);
                    end
                end
                PH_HI_U: begin
                    if (b == CH_LO_U) begin
                        hex_clear(s);
                        s.ph = PH_HI_HEX;
                    end else begin
                        s.ph = PH_STR;
                        if (put(1'b0, CP_REPL, i_cap, s, c)) do_esc(b, i_cap, s, c);
                    end
                end
                PH_HI_HEX: begin
                    hex_take(b, s);
                    if (s.hcnt >= 3'd4) begin
                        s.ph = PH_STR;
                        if (!s.hbad && s.hacc >= LO_SUR_LO && s.hacc <= LO_SUR_HI) begin
                            // pair: 0x10000 + high10 << 10 + low10
                            void'(put(1'b0, CP_SUPP + {1'b0, s.pend, s.hacc[9:0]},
                                      i_cap, s, c));
                        end else if (put(1'b0, CP_REPL, i_cap, s, c)) begin
                            finish_u(s.hacc, s.hbad, i_cap, s, c);
                        end
                    end
                end
                PH_DONE: s.ph = PH_DONE;
            endcase
        end

        if (i_in.span_end) begin
            unique case (s.ph)
                PH_WS:          finish(ST_NOSTR, s, c);
                PH_STR, PH_HEX: finish(ST_OK, s, c);
                PH_ESC: begin
                    if (put(1'b1, {13'd0, CH_BSLASH}, i_cap, s, c)) finish(ST_OK, s, c);
                end
                PH_HI_BS, PH_HI_HEX: begin
                    s.ph = PH_STR;
                    if (put(1'b0, CP_REPL, i_cap, s, c)) finish(ST_OK, s, c);
                end
                PH_HI_U: begin
                    s.ph = PH_STR;
                    if (put(1'b0, CP_REPL, i_cap, s, c)) begin
                        if (put(1'b1, {13'd0, CH_BSLASH}, i_cap, s, c)) finish(ST_OK, s, c);
                    end
                end
                PH_DONE: s.ph = PH_DONE;
            endcase
            s.ph   = PH_WS;
            hex_clear(s);
            s.pend = '0;
            s.bw   = '0;
        end

        n_st   = s;
        o_cmd  = c;
        o_push = w_acc && (c.n != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.ph   <= PH_WS;
            r_st.hcnt <= '0;
            r_st.hacc <= '0;
            r_st.hbad <= 1'b0;
            r_st.pend <= '0;
            r_st.bw   <= '0;
        end else if (w_acc) begin
            r_st <= n_st;
        end
    end

endmodule

// File: src/jsu_cmdq.sv
module jsu_cmdq #(
    parameter int DEPTH = jsu_pkg::QDEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output jsu_pkg::t_cmd o_head,
    output logic          o_empty
);
    import jsu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("cmdq count above depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("cmdq pop while empty");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("cmdq push lost");

endmodule

// File: src/jsu_back.sv
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jsu_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    jsu_out_if.source     o_res
);
    import jsu_pkg::*;

    logic [1:0] r_uidx, r_bidx;
    logic       r_ovalid;
    logic [7:0] r_byte;
    logic       r_is_stat;
    logic [1:0] r_stat;
    logic       r_last;

    t_unit      w_u;
    logic [2:0] w_len;
    logic [1:0] w_rem;
    logic [7:0] w_byte;
    logic       w_ulast, w_clast, w_adv, w_fire;

    always_comb begin
        w_u    = i_head.u[r_uidx];
        w_len  = (w_u.kind == U_CP) ? cp_len(w_u.val) : 3'd1;
        // continuation bytes left after this one
        w_rem  = 2'(w_len - 3'd1 - {1'b0, r_bidx});
        w_byte = 8'd0;
        unique case (w_u.kind)
            U_CP: begin
                if (r_bidx != 2'd0) begin
                    unique case (w_rem)
                        2'd0:    w_byte = UTF_CONT | {2'b0, w_u.val[5:0]};
                        2'd1:    w_byte = UTF_CONT | {2'b0, w_u.val[11:6]};
                        default: w_byte = UTF_CONT | {2'b0, w_u.val[17:12]};
                    endcase
                end else begin
                    unique case (w_len)
                        3'd1:    w_byte = w_u.val[7:0];
                        3'd2:    w_byte = UTF_LEAD2 | {3'b0, w_u.val[10:6]};
                        3'd3:    w_byte = UTF_LEAD3 | {4'b0, w_u.val[15:12]};
                        default: w_byte = UTF_LEAD4 | {5'b0, w_u.val[20:18]};
                    endcase
                end
            end
            U_RAW:  w_byte = w_u.val[7:0];
            U_STAT: w_byte = 8'd0;
            U_NONE: w_byte = 8'd0;
        endcase
        w_ulast = (w_rem == 2'd0);
        w_clast = w_ulast && (r_uidx == 2'(i_head.n - 2'd1));
        w_adv   = !r_ovalid || o_res.ready;
        w_fire  = w_adv && !i_empty;
        o_pop   = w_fire && w_clast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uidx   <= '0;
            r_bidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_adv) r_ovalid <= !i_empty;
            if (w_fire) begin
                if (w_clast) begin
                    r_uidx <= '0;
                    r_bidx <= '0;
                end else if (w_ulast) begin
                    r_uidx <= r_uidx + 2'd1;
                    r_bidx <= '0;
                end else begin
                    r_bidx <= r_bidx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_byte    <= w_byte;
            r_is_stat <= (w_u.kind == U_STAT);
            r_stat    <= (w_u.kind == U_STAT) ? w_u.val[1:0] : ST_NOSTR;
            r_last    <= w_clast;
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.out_byte  = r_byte;
    assign o_res.is_status = r_is_stat;
    assign o_res.status    = r_stat;
    assign o_res.run_last  = r_last;

    a_byte_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_is_stat) |-> (r_stat == ST_NOSTR))
        else $error("status set on a data byte");
    a_status_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_is_stat) |-> (r_last && r_byte == 8'd0))
        else $error("status result not last of its transfer");
    a_mid_cmd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_uidx != 2'd0 || r_bidx != 2'd0) |-> !i_empty)
        else $error("command left queue before all bytes sent");

endmodule

// File: src/json_string_unescape_utf8.sv
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    in_byte[7:0], has_byte, span_end
// o_res     out  valid/ready    out_byte[7:0], is_status, status[1:0], run_last
// cfg       in   i_cfg_we       i_cfg_wdata[15:0] = out_capacity
//
// One input transfer per cycle is taken while the command queue has room; the
// front decodes a byte in the cycle it arrives. Results leave at one per cycle
// from the output register while o_res is ready, so an input transfer with k
// results (k up to 7) holds the back end until all k have left. The first
// result passes the queue memory and then the output register before it is valid.
// Reset (synchronous, active low) returns the decoder to leading whitespace,
// empties the queue and sets capacity to 256. Output stalls back up through
// the queue; i_in.ready drops only when the queue is full.
module json_string_unescape_utf8 #(
    parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEF,
    parameter int Q_DEPTH     = jsu_pkg::QDEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jsu_pkg::CAP_WIDTH-1:0] i_cfg_wdata,
    jsu_in_if.sink                        i_in,
    jsu_out_if.source                     o_res
);
    import jsu_pkg::*;

    // output capacity register (includes room for a terminator)
    logic [CAP_WIDTH-1:0] r_cap;

    // front -> queue -> back
    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_in, q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // front: whitespace/quote check, escape and surrogate decoding, capacity
    // accounting; packs each transfer's results into one command
    jsu_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cap    (r_cap),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    // short command queue lets front and back stall independently
    jsu_cmdq #(
        .DEPTH(Q_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    // back: UTF-8 encode and serialize one result per cycle while o_res is ready
    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule
